// ----- design/cpu65_pkg.sv -----
// Shared types for the 6502 execute unit: transaction payloads, register file and operation codes.
`default_nettype none
package cpu65_pkg;

	typedef struct packed {
		logic [7:0] req_type;
		logic [7:0] operand;
	} req_t;

	typedef struct packed {
		logic [7:0] write_data;
		logic       write_enable;
		logic       branch_taken;
		logic [7:0] status_out;
		logic [7:0] acc_out;
		logic [7:0] x_out;
		logic [7:0] y_out;
		logic       unknown_opcode;
	} rsp_t;

	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] p;
	} arch_t;

	typedef enum logic [5:0] {
		OP_UNKNOWN,
		OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_STA, OP_LDA, OP_CMP,
		OP_SHIFT_A, OP_SHIFT_M,
		OP_STX, OP_TXA, OP_LDX, OP_TAX, OP_DEC, OP_DEX, OP_INC, OP_NOP,
		OP_BIT, OP_STY, OP_LDY, OP_CPY, OP_CPX,
		OP_PHP, OP_PLP, OP_PHA, OP_DEY, OP_TAY, OP_INY, OP_INX,
		OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_TYA, OP_CLV, OP_CLD,
		OP_BRANCH
	} op_t;

endpackage
`default_nettype wire

// ----- design/cpu65_decode.sv -----
// Opcode decoder: splits the opcode into its aaa/bbb/cc fields and maps it to an operation.
`default_nettype none
module cpu65_decode
	import cpu65_pkg::*;
(
	input  wire logic [7:0] opcode,
	output op_t             op
);

	// cc column
	localparam logic [1:0] GRP_CTL = 2'b00;
	localparam logic [1:0] GRP_ALU = 2'b01;
	localparam logic [1:0] GRP_RMW = 2'b10;

	// bbb addressing rows
	localparam logic [2:0] BBB_IMM    = 3'b000;
	localparam logic [2:0] BBB_ZP     = 3'b001;
	localparam logic [2:0] BBB_IMPL   = 3'b010;
	localparam logic [2:0] BBB_ABS    = 3'b011;
	localparam logic [2:0] BBB_BRANCH = 3'b100;
	localparam logic [2:0] BBB_ZPX    = 3'b101;
	localparam logic [2:0] BBB_FLAG   = 3'b110;
	localparam logic [2:0] BBB_ABSX   = 3'b111;
	localparam logic [2:0] BBB_ALU_IMM = 3'b010;

	// aaa codes, ALU column
	localparam logic [2:0] ALU_ORA = 3'd0;
	localparam logic [2:0] ALU_AND = 3'd1;
	localparam logic [2:0] ALU_EOR = 3'd2;
	localparam logic [2:0] ALU_ADC = 3'd3;
	localparam logic [2:0] ALU_STA = 3'd4;
	localparam logic [2:0] ALU_LDA = 3'd5;
	localparam logic [2:0] ALU_CMP = 3'd6;

	// aaa codes, read-modify-write column
	localparam logic [2:0] RMW_STX = 3'd4;
	localparam logic [2:0] RMW_LDX = 3'd5;
	localparam logic [2:0] RMW_DEC = 3'd6;
	localparam logic [2:0] RMW_INC = 3'd7;

	// aaa codes, control column
	localparam logic [2:0] CTL_BIT = 3'd1;
	localparam logic [2:0] CTL_STY = 3'd4;
	localparam logic [2:0] CTL_LDY = 3'd5;
	localparam logic [2:0] CTL_CPY = 3'd6;
	localparam logic [2:0] CTL_CPX = 3'd7;

	// aaa codes, implied row of the control column
	localparam logic [2:0] IMP_PHP = 3'd0;
	localparam logic [2:0] IMP_PLP = 3'd1;
	localparam logic [2:0] IMP_PHA = 3'd2;
	localparam logic [2:0] IMP_DEY = 3'd4;
	localparam logic [2:0] IMP_TAY = 3'd5;
	localparam logic [2:0] IMP_INY = 3'd6;
	localparam logic [2:0] IMP_INX = 3'd7;

	// aaa codes, flag row of the control column
	localparam logic [2:0] FLG_CLC = 3'd0;
	localparam logic [2:0] FLG_SEC = 3'd1;
	localparam logic [2:0] FLG_CLI = 3'd2;
	localparam logic [2:0] FLG_SEI = 3'd3;
	localparam logic [2:0] FLG_TYA = 3'd4;
	localparam logic [2:0] FLG_CLV = 3'd5;
	localparam logic [2:0] FLG_CLD = 3'd6;

	logic [2:0] aaa;
	logic [2:0] bbb;
	logic [1:0] cc;
	logic       mem_row;

	assign aaa = opcode[7:5];
	assign bbb = opcode[4:2];
	assign cc  = opcode[1:0];
	// zp, abs, zp-indexed and abs-indexed rows, used by the RMW and control columns
	assign mem_row = (bbb == BBB_ZP) || (bbb == BBB_ABS) || (bbb == BBB_ZPX)
		|| (bbb == BBB_ABSX);

	always_comb begin
		op = OP_UNKNOWN;
		case (cc)
			GRP_ALU: begin
				case (aaa)
					ALU_ORA: op = OP_ORA;
					ALU_AND: op = OP_AND;
					ALU_EOR: op = OP_EOR;
					ALU_ADC: op = OP_ADC;
					ALU_STA: op = (bbb == BBB_ALU_IMM) ? OP_UNKNOWN : OP_STA;
					ALU_LDA: op = OP_LDA;
					ALU_CMP: op = OP_CMP;
					default: op = OP_UNKNOWN;
				endcase
			end
			GRP_RMW: begin
				case (aaa)
					RMW_STX: begin
						if (bbb == BBB_IMPL)
							op = OP_TXA;
						else if ((bbb == BBB_ZP) || (bbb == BBB_ABS) || (bbb == BBB_ZPX))
							op = OP_STX;
					end
					RMW_LDX: begin
						if (bbb == BBB_IMPL)
							op = OP_TAX;
						else if ((bbb == BBB_IMM) || mem_row)
							op = OP_LDX;
					end
					RMW_DEC: begin
						if (bbb == BBB_IMPL)
							op = OP_DEX;
						else if (mem_row)
							op = OP_DEC;
					end
					RMW_INC: begin
						if (bbb == BBB_IMPL)
							op = OP_NOP;
						else if (mem_row)
							op = OP_INC;
					end
					default: begin
						// ASL, ROL, LSR, ROR
						if (bbb == BBB_IMPL)
							op = OP_SHIFT_A;
						else if (mem_row)
							op = OP_SHIFT_M;
					end
				endcase
			end
			GRP_CTL: begin
				case (bbb)
					BBB_BRANCH: op = OP_BRANCH;
					BBB_IMPL: begin
						case (aaa)
							IMP_PHP: op = OP_PHP;
							IMP_PLP: op = OP_PLP;
							IMP_PHA: op = OP_PHA;
							IMP_DEY: op = OP_DEY;
							IMP_TAY: op = OP_TAY;
							IMP_INY: op = OP_INY;
							IMP_INX: op = OP_INX;
							default: op = OP_UNKNOWN;
						endcase
					end
					BBB_FLAG: begin
						case (aaa)
							FLG_CLC: op = OP_CLC;
							FLG_SEC: op = OP_SEC;
							FLG_CLI: op = OP_CLI;
							FLG_SEI: op = OP_SEI;
							FLG_TYA: op = OP_TYA;
							FLG_CLV: op = OP_CLV;
							FLG_CLD: op = OP_CLD;
							default: op = OP_UNKNOWN;
						endcase
					end
					default: begin
						case (aaa)
							CTL_BIT: begin
								if ((bbb == BBB_ZP) || (bbb == BBB_ABS))
									op = OP_BIT;
							end
							CTL_STY: begin
								if ((bbb == BBB_ZP) || (bbb == BBB_ABS) || (bbb == BBB_ZPX))
									op = OP_STY;
							end
							CTL_LDY: begin
								if ((bbb == BBB_IMM) || mem_row)
									op = OP_LDY;
							end
							CTL_CPY: begin
								if ((bbb == BBB_IMM) || (bbb == BBB_ZP) || (bbb == BBB_ABS))
									op = OP_CPY;
							end
							CTL_CPX: begin
								if ((bbb == BBB_IMM) || (bbb == BBB_ZP) || (bbb == BBB_ABS))
									op = OP_CPX;
							end
							default: op = OP_UNKNOWN;
						endcase
					end
				endcase
			end
			default: op = OP_UNKNOWN;
		endcase
	end

endmodule
`default_nettype wire

// ----- design/cpu65_exec.sv -----
// Execute datapath: computes next A/X/Y/P, write byte and branch condition for one operation.
`default_nettype none
module cpu65_exec
	import cpu65_pkg::*;
(
	input  wire op_t        op,
	input  wire logic [7:0] opcode,
	input  wire logic [7:0] operand,
	input  wire arch_t      cur,
	output arch_t           nxt,
	output rsp_t            rsp
);

	localparam int FL_C = 0;
	localparam int FL_Z = 1;
	localparam int FL_I = 2;
	localparam int FL_D = 3;
	localparam int FL_V = 6;
	localparam int FL_N = 7;

	localparam logic [7:0] PUSH_BITS = 8'h30;
	localparam logic [7:0] PULL_MASK = 8'hCF;

	localparam logic [1:0] SH_ASL = 2'd0;
	localparam logic [1:0] SH_ROL = 2'd1;
	localparam logic [1:0] SH_LSR = 2'd2;

	localparam logic [1:0] BR_N = 2'd0;
	localparam logic [1:0] BR_V = 2'd1;
	localparam logic [1:0] BR_C = 2'd2;

	function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r = p;
		r[FL_N] = v[7];
		r[FL_Z] = (v == 8'h00);
		return r;
	endfunction

	function automatic logic [7:0] set_cmp(input logic [7:0] p, input logic [7:0] r,
		input logic [7:0] m);
		logic [7:0] q;
		q = set_nz(p, r - m);
		q[FL_C] = (r >= m);
		return q;
	endfunction

	logic [7:0] a, m;
	logic [7:0] p;
	logic [1:0] sh_kind;
	logic [7:0] sh_in;
	logic [7:0] sh_res;
	logic       sh_cout;
	logic [8:0] sum;
	logic       ovf;
	logic       br_flag;

	assign a = cur.acc;
	assign m = operand;
	assign p = cur.p;
	assign sh_kind = opcode[6:5];
	assign sh_in = (op == OP_SHIFT_A) ? a : m;

	// shared shifter for the accumulator and memory forms
	always_comb begin
		case (sh_kind)
			SH_ASL: begin
				sh_res  = {sh_in[6:0], 1'b0};
				sh_cout = sh_in[7];
			end
			SH_ROL: begin
				sh_res  = {sh_in[6:0], p[FL_C]};
				sh_cout = sh_in[7];
			end
			SH_LSR: begin
				sh_res  = {1'b0, sh_in[7:1]};
				sh_cout = sh_in[0];
			end
			default: begin
				sh_res  = {p[FL_C], sh_in[7:1]};
				sh_cout = sh_in[0];
			end
		endcase
	end

	assign sum = {1'b0, a} + {1'b0, m} + {8'h00, p[FL_C]};
	assign ovf = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);

	always_comb begin
		case (opcode[7:6])
			BR_N:    br_flag = p[FL_N];
			BR_V:    br_flag = p[FL_V];
			BR_C:    br_flag = p[FL_C];
			default: br_flag = p[FL_Z];
		endcase
	end

	always_comb begin
		nxt = cur;
		rsp.write_data     = 8'h00;
		rsp.write_enable   = 1'b0;
		rsp.branch_taken   = 1'b0;
		rsp.unknown_opcode = 1'b0;
		case (op)
			OP_ORA: begin
				nxt.acc = a | m;
				nxt.p   = set_nz(p, a | m);
			end
			OP_AND: begin
				nxt.acc = a & m;
				nxt.p   = set_nz(p, a & m);
			end
			OP_EOR: begin
				nxt.acc = a ^ m;
				nxt.p   = set_nz(p, a ^ m);
			end
			OP_ADC: begin
				nxt.acc      = sum[7:0];
				nxt.p        = set_nz(p, sum[7:0]);
				nxt.p[FL_C]  = sum[8];
				nxt.p[FL_V]  = ovf;
			end
			OP_SHIFT_A: begin
				nxt.acc     = sh_res;
				nxt.p       = set_nz(p, sh_res);
				nxt.p[FL_C] = sh_cout;
			end
			OP_SHIFT_M: begin
				rsp.write_data   = sh_res;
				rsp.write_enable = 1'b1;
				nxt.p            = set_nz(p, sh_res);
				nxt.p[FL_C]      = sh_cout;
			end
			OP_BIT: begin
				nxt.p[FL_N] = m[7];
				nxt.p[FL_V] = m[6];
				nxt.p[FL_Z] = ((a & m) == 8'h00);
			end
			OP_CMP: nxt.p = set_cmp(p, a, m);
			OP_CPX: nxt.p = set_cmp(p, cur.x, m);
			OP_CPY: nxt.p = set_cmp(p, cur.y, m);
			OP_LDA: begin
				nxt.acc = m;
				nxt.p   = set_nz(p, m);
			end
			OP_LDX: begin
				nxt.x = m;
				nxt.p = set_nz(p, m);
			end
			OP_LDY: begin
				nxt.y = m;
				nxt.p = set_nz(p, m);
			end
			OP_TAX: begin
				nxt.x = a;
				nxt.p = set_nz(p, a);
			end
			OP_TAY: begin
				nxt.y = a;
				nxt.p = set_nz(p, a);
			end
			OP_TXA: begin
				nxt.acc = cur.x;
				nxt.p   = set_nz(p, cur.x);
			end
			OP_TYA: begin
				nxt.acc = cur.y;
				nxt.p   = set_nz(p, cur.y);
			end
			OP_INC: begin
				rsp.write_data   = m + 8'h01;
				rsp.write_enable = 1'b1;
				nxt.p            = set_nz(p, m + 8'h01);
			end
			OP_DEC: begin
				rsp.write_data   = m - 8'h01;
				rsp.write_enable = 1'b1;
				nxt.p            = set_nz(p, m - 8'h01);
			end
			OP_INX: begin
				nxt.x = cur.x + 8'h01;
				nxt.p = set_nz(p, cur.x + 8'h01);
			end
			OP_DEX: begin
				nxt.x = cur.x - 8'h01;
				nxt.p = set_nz(p, cur.x - 8'h01);
			end
			OP_INY: begin
				nxt.y = cur.y + 8'h01;
				nxt.p = set_nz(p, cur.y + 8'h01);
			end
			OP_DEY: begin
				nxt.y = cur.y - 8'h01;
				nxt.p = set_nz(p, cur.y - 8'h01);
			end
			OP_CLC: nxt.p[FL_C] = 1'b0;
			OP_SEC: nxt.p[FL_C] = 1'b1;
			OP_CLI: nxt.p[FL_I] = 1'b0;
			OP_SEI: nxt.p[FL_I] = 1'b1;
			OP_CLV: nxt.p[FL_V] = 1'b0;
			OP_CLD: nxt.p[FL_D] = 1'b0;
			OP_PHP: begin
				// pushed copy carries B and the unused bit set
				rsp.write_data   = p | PUSH_BITS;
				rsp.write_enable = 1'b1;
			end
			OP_PLP: nxt.p = m & PULL_MASK;
			OP_PHA, OP_STA: begin
				rsp.write_data   = a;
				rsp.write_enable = 1'b1;
			end
			OP_STX: begin
				rsp.write_data   = cur.x;
				rsp.write_enable = 1'b1;
			end
			OP_STY: begin
				rsp.write_data   = cur.y;
				rsp.write_enable = 1'b1;
			end
			OP_BRANCH: rsp.branch_taken = (br_flag == opcode[5]);
			OP_NOP: ;
			default: rsp.unknown_opcode = 1'b1;
		endcase
		rsp.status_out = nxt.p;
		rsp.acc_out    = nxt.acc;
		rsp.x_out      = nxt.x;
		rsp.y_out      = nxt.y;
	end

endmodule
`default_nettype wire

// ----- design/cpu_6502_execute_unit.sv -----
// Top level of the 6502 execute unit: input register, register file, result register.
// Executes one 6502 opcode per transaction on an operand byte that an outside sequencer already
// fetched, keeping A, X, Y and P. A transaction is captured in an input register, executed by
// combinational decode and 8-bit ALU logic against the register file, and its result is written
// into the result register. One transaction is accepted every cycle while results are taken; a
// stalled result holds the input register, which then stalls the request side. The register file
// updates as each result is registered, so a following opcode sees its predecessor's effect with
// no gap. Only binary arithmetic is done; SBC, SED, PLA, stack pointer, jumps, interrupts and
// unofficial opcodes report unknown_opcode and change nothing.
`default_nettype none
module cpu_6502_execute_unit
	import cpu65_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic  valid_s1;
	req_t  req_s1;
	arch_t arch_q;
	arch_t arch_nxt;
	op_t   op;
	rsp_t  rsp_nxt;
	logic  rsp_valid_q;
	rsp_t  rsp_q;
	logic  advance;
	logic  accept;

	// advance the input register into the result register when the latter is free or draining
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	cpu65_decode u_decode (
		.opcode (req_s1.req_type),
		.op     (op)
	);

	cpu65_exec u_exec (
		.op      (op),
		.opcode  (req_s1.req_type),
		.operand (req_s1.operand),
		.cur     (arch_q),
		.nxt     (arch_nxt),
		.rsp     (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			arch_q      <= arch_nxt;
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// reported registers match the register file right after a result is registered
	a_arch_matches_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (arch_q.acc == rsp_q.acc_out) && (arch_q.x == rsp_q.x_out)
			&& (arch_q.y == rsp_q.y_out) && (arch_q.p == rsp_q.status_out))
		else $error("register file differs from reported result");

	// an unknown opcode leaves the register file untouched
	a_unknown_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rsp_nxt.unknown_opcode |=> arch_q == $past(arch_q))
		else $error("unknown opcode changed register state");

	// an unknown opcode never writes or branches
	a_unknown_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.unknown_opcode |-> !rsp_q.write_enable && !rsp_q.branch_taken)
		else $error("unknown opcode reported a write or branch");

	// hold the input register while the result register is blocked
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && rsp_stall |=> valid_s1 && $stable(req_s1))
		else $error("input register lost a pending transaction");

endmodule
`default_nettype wire
